/* rtl/drp_pkg.sv */
`default_nettype none

package drp_pkg;

    localparam int PIXEL_W  = 12;
    localparam int DEPTH_W  = 16;
    localparam int RAY_W    = 16;
    localparam int POINT_W  = 18;
    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 4;
    localparam int RADIUS_W = 14;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    localparam int PROD_W  = RAY_W + DEPTH_W + 1;
    localparam int XSQ_W   = 2 * POINT_W - 1;
    localparam int DSQ_W   = 2 * DEPTH_W;
    localparam int RSQ_W   = 2 * RADIUS_W;
    localparam int LEN2_W  = XSQ_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_PIXEL_STRIDE = 2'd2,
        CFG_RADIUS_MM    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
        logic adv4;
    } adv_t;

endpackage

`default_nettype wire

/* rtl/drp_grid_check.sv */
`default_nettype none

module drp_grid_check (
    input  wire logic                            aclk,
    input  wire drp_pkg::adv_t                   adv,
    input  wire logic [drp_pkg::STRIDE_W-1:0]    stride,
    input  wire logic [drp_pkg::PIXEL_W-1:0]     px_in,
    input  wire logic [drp_pkg::PIXEL_W-1:0]     py_in,
    input  wire logic [drp_pkg::PIXEL_W-1:0]     px1,
    input  wire logic [drp_pkg::PIXEL_W-1:0]     py1,
    output logic                                 grid_ok
);

    localparam int HALF_W = drp_pkg::PIXEL_W / 2;

    logic [drp_pkg::STRIDE_W-1:0] remx1_reg, remy1_reg, remx2_reg, remy2_reg;
    logic [drp_pkg::STRIDE_W-1:0] remx1_next, remy1_next, remx2_next, remy2_next;

    function automatic logic [drp_pkg::STRIDE_W-1:0] rem_steps(
        input logic [drp_pkg::STRIDE_W-1:0] r_in,
        input logic [HALF_W-1:0]            bits,
        input logic [drp_pkg::STRIDE_W-1:0] s
    );
        logic [drp_pkg::STRIDE_W-1:0] r;
        logic [drp_pkg::STRIDE_W:0]   t;
        r = r_in;
        for (int i = HALF_W - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, s}) begin
                t = t - {1'b0, s};
            end
            r = t[drp_pkg::STRIDE_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        remx1_next = rem_steps('0, px_in[drp_pkg::PIXEL_W-1:HALF_W], stride);
        remy1_next = rem_steps('0, py_in[drp_pkg::PIXEL_W-1:HALF_W], stride);
        remx2_next = rem_steps(remx1_reg, px1[HALF_W-1:0], stride);
        remy2_next = rem_steps(remy1_reg, py1[HALF_W-1:0], stride);
    end

    always_ff @(posedge aclk) begin
        if (adv.adv1) begin
            remx1_reg <= remx1_next;
            remy1_reg <= remy1_next;
        end
        if (adv.adv2) begin
            remx2_reg <= remx2_next;
            remy2_reg <= remy2_next;
        end
    end

    assign grid_ok = (remx2_reg == '0) && (remy2_reg == '0);

endmodule

`default_nettype wire

/* rtl/drp_project.sv */
`default_nettype none

module drp_project #(
    parameter int RAY_FRAC_BITS = 14
) (
    input  wire logic                                aclk,
    input  wire drp_pkg::adv_t                       adv,
    input  wire logic signed [drp_pkg::RAY_W-1:0]    ray_x,
    input  wire logic signed [drp_pkg::RAY_W-1:0]    ray_y,
    input  wire logic [drp_pkg::DEPTH_W-1:0]         depth,
    output logic signed [drp_pkg::POINT_W-1:0]       point_x,
    output logic signed [drp_pkg::POINT_W-1:0]       point_y
);

    localparam logic signed [drp_pkg::PROD_W-1:0] SAT_MAX =
        drp_pkg::PROD_W'((1 << (drp_pkg::POINT_W - 1)) - 1);
    localparam logic signed [drp_pkg::PROD_W-1:0] SAT_MIN = -SAT_MAX - 1;

    logic signed [drp_pkg::PROD_W-1:0] prodx_reg, prody_reg;
    logic signed [drp_pkg::PROD_W-1:0] prodx_next, prody_next;
    logic signed [drp_pkg::PROD_W-1:0] shx, shy;
    logic signed [drp_pkg::POINT_W-1:0] ptx_reg, pty_reg, ptx_next, pty_next;
    logic signed [drp_pkg::DEPTH_W:0] depth_s;

    function automatic logic signed [drp_pkg::POINT_W-1:0] saturate(
        input logic signed [drp_pkg::PROD_W-1:0] v
    );
        logic signed [drp_pkg::PROD_W-1:0] c;
        c = v;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end else if (v < SAT_MIN) begin
            c = SAT_MIN;
        end
        return c[drp_pkg::POINT_W-1:0];
    endfunction

    always_comb begin
        depth_s    = $signed({1'b0, depth});
        prodx_next = ray_x * depth_s;
        prody_next = ray_y * depth_s;
        shx        = prodx_reg >>> RAY_FRAC_BITS;
        shy        = prody_reg >>> RAY_FRAC_BITS;
        ptx_next   = saturate(shx);
        pty_next   = saturate(shy);
    end

    always_ff @(posedge aclk) begin
        if (adv.adv1) begin
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
        end
        if (adv.adv2) begin
            ptx_reg <= ptx_next;
            pty_reg <= pty_next;
        end
    end

    assign point_x = ptx_reg;
    assign point_y = pty_reg;

endmodule

`default_nettype wire

/* rtl/drp_length.sv */
`default_nettype none

module drp_length (
    input  wire logic                                aclk,
    input  wire drp_pkg::adv_t                       adv,
    input  wire logic signed [drp_pkg::POINT_W-1:0]  point_x,
    input  wire logic signed [drp_pkg::POINT_W-1:0]  point_y,
    input  wire logic [drp_pkg::DEPTH_W-1:0]         depth,
    input  wire logic [drp_pkg::RADIUS_W-1:0]        radius,
    output logic                                     in_range
);

    logic signed [2*drp_pkg::POINT_W-1:0] xsq, ysq;
    logic [drp_pkg::DSQ_W-1:0]  dsq;
    logic [drp_pkg::RSQ_W-1:0]  rsq;
    logic [drp_pkg::XSQ_W-1:0]  xx_reg, yy_reg;
    logic [drp_pkg::DSQ_W-1:0]  dd_reg;
    logic [drp_pkg::RSQ_W-1:0]  rr_reg;
    logic [drp_pkg::LEN2_W-1:0] len2;

    always_comb begin
        xsq  = point_x * point_x;
        ysq  = point_y * point_y;
        dsq  = depth * depth;
        rsq  = radius * radius;
        len2 = {2'b0, xx_reg} + {2'b0, yy_reg}
             + {{(drp_pkg::LEN2_W - drp_pkg::DSQ_W){1'b0}}, dd_reg};
        in_range = (len2 != '0)
                && (len2 < {{(drp_pkg::LEN2_W - drp_pkg::RSQ_W){1'b0}}, rr_reg});
    end

    always_ff @(posedge aclk) begin
        if (adv.adv3) begin
            xx_reg <= xsq[drp_pkg::XSQ_W-1:0];
            yy_reg <= ysq[drp_pkg::XSQ_W-1:0];
            dd_reg <= dsq;
            rr_reg <= rsq;
        end
    end

endmodule

`default_nettype wire

/* rtl/depth_ray_point_projector.sv */
`default_nettype none
// channel | direction | tdata fields (lsb up)                              | tuser
// s_      | in        | pixel_x 12, pixel_y 12, depth_mm 16, ray_x 16, ray_y 16 | ray_defined
// m_      | out       | point_x 18, point_y 18, point_z 16, tex_u 12, tex_v 12, pad 4 | none
// cfg_wr  | in        | index 0 width, 1 height, 2 stride, 3 radius          | none
// One pixel enters per cycle while s_tready is high; a stalled output can drop it.
// Each pixel passes the four-stage pipe: grid remainder and projection multiply,
// remainder finish and saturate, squaring, and the length compare feeding the output register.
// Rejected pixels leave a bubble and produce no result.
// A stalled output holds its point; upstream stages keep moving into bubbles.
// Synchronous reset clears valid bits and reloads the register defaults.

module depth_ray_point_projector #(
    parameter int MAX_DIM       = 4096,
    parameter int RAY_FRAC_BITS = 14
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pixel_x, pixel_y, depth_mm, ray_x, ray_y
    input  wire logic [drp_pkg::S_TDATA_W-1:0]     s_tdata,
    // ray_defined
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // point_x, point_y, point_z, tex_u, tex_v, zero pad
    output logic [drp_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [drp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [drp_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int BND_W = drp_pkg::DIM_W + 1;
    localparam logic [BND_W-1:0] DIM_LIMIT = BND_W'(MAX_DIM);

    logic [drp_pkg::DIM_W-1:0]    width_reg, height_reg;
    logic [drp_pkg::STRIDE_W-1:0] stride_reg;
    logic [drp_pkg::RADIUS_W-1:0] radius_reg;

    logic [drp_pkg::PIXEL_W-1:0]  px_in, py_in;
    logic [drp_pkg::DEPTH_W-1:0]  depth_in;
    logic signed [drp_pkg::RAY_W-1:0] rx_in, ry_in;

    logic [BND_W-1:0] w_clamp, h_clamp, sum_x, sum_y;
    logic             keep_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic k1_reg, k2_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    drp_pkg::adv_t adv;

    logic [drp_pkg::PIXEL_W-1:0] px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic [drp_pkg::PIXEL_W-1:0] px4_reg, py4_reg;
    logic [drp_pkg::DEPTH_W-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [drp_pkg::POINT_W-1:0] x2, y2, x3_reg, y3_reg, x4_reg, y4_reg;

    logic grid_ok, in_range;

    always_comb begin
        px_in    = s_tdata[11:0];
        py_in    = s_tdata[23:12];
        depth_in = s_tdata[39:24];
        rx_in    = $signed(s_tdata[55:40]);
        ry_in    = $signed(s_tdata[71:56]);

        w_clamp = ({1'b0, width_reg} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, width_reg};
        h_clamp = ({1'b0, height_reg} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, height_reg};
        sum_x   = {{(BND_W - drp_pkg::PIXEL_W){1'b0}}, px_in}
                + {{(BND_W - drp_pkg::STRIDE_W){1'b0}}, stride_reg};
        sum_y   = {{(BND_W - drp_pkg::PIXEL_W){1'b0}}, py_in}
                + {{(BND_W - drp_pkg::STRIDE_W){1'b0}}, stride_reg};

        keep_next = (stride_reg != '0) && (sum_x < w_clamp) && (sum_y < h_clamp)
                 && (depth_in != '0) && s_tuser
                 && ((rx_in != '0) || (ry_in != '0));

        rdy4 = !v4_reg || m_tready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        adv.adv1 = rdy1;
        adv.adv2 = rdy2;
        adv.adv3 = rdy3;
        adv.adv4 = rdy4;
    end

    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= drp_pkg::DIM_W'(1280);
            height_reg <= drp_pkg::DIM_W'(720);
            stride_reg <= drp_pkg::STRIDE_W'(2);
            radius_reg <= drp_pkg::RADIUS_W'(6000);
        end else if (cfg_wr_en) begin
            unique case (drp_pkg::cfg_index_t'(cfg_wr_index))
                drp_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[drp_pkg::DIM_W-1:0];
                drp_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wr_data[drp_pkg::DIM_W-1:0];
                drp_pkg::CFG_PIXEL_STRIDE: stride_reg <= cfg_wr_data[drp_pkg::STRIDE_W-1:0];
                drp_pkg::CFG_RADIUS_MM:    radius_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg && k2_reg && grid_ok;
            if (rdy4) v4_reg <= v3_reg && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.adv1) begin
            k1_reg  <= keep_next;
            px1_reg <= px_in;
            py1_reg <= py_in;
            d1_reg  <= depth_in;
        end
        if (adv.adv2) begin
            k2_reg  <= k1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            d2_reg  <= d1_reg;
        end
        if (adv.adv3) begin
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            d3_reg  <= d2_reg;
            x3_reg  <= x2;
            y3_reg  <= y2;
        end
        if (adv.adv4) begin
            px4_reg <= px3_reg;
            py4_reg <= py3_reg;
            d4_reg  <= d3_reg;
            x4_reg  <= x3_reg;
            y4_reg  <= y3_reg;
        end
    end

    drp_grid_check u_grid (
        .aclk    (aclk),
        .adv     (adv),
        .stride  (stride_reg),
        .px_in   (px_in),
        .py_in   (py_in),
        .px1     (px1_reg),
        .py1     (py1_reg),
        .grid_ok (grid_ok)
    );

    drp_project #(
        .RAY_FRAC_BITS (RAY_FRAC_BITS)
    ) u_project (
        .aclk    (aclk),
        .adv     (adv),
        .ray_x   (rx_in),
        .ray_y   (ry_in),
        .depth   (depth_in),
        .point_x (x2),
        .point_y (y2)
    );

    drp_length u_length (
        .aclk     (aclk),
        .adv      (adv),
        .point_x  (x2),
        .point_y  (y2),
        .depth    (d2_reg),
        .radius   (radius_reg),
        .in_range (in_range)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {4'b0, py4_reg, px4_reg, d4_reg, y4_reg, x4_reg};

endmodule

`default_nettype wire

/* rtl/drp_checker.sv */
`default_nettype none

module drp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [drp_pkg::M_TDATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[51:36] != '0) && (m_tdata[51:50] == 2'b00))
        else $error("point_z outside radius bound");

    a_x_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:14] == 4'h0) || (m_tdata[17:14] == 4'hF))
        else $error("point_x outside radius bound");

endmodule

bind depth_ray_point_projector drp_checker u_drp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
